// ----- hw/rtl/banded_linear_gap_global_alignment_defines.svh -----
// ----------------------------------------------------------------------------
// banded_linear_gap_global_alignment_defines
// Assertion macros shared by the alignment block.
// ----------------------------------------------------------------------------
`ifndef BANDED_LINEAR_GAP_GLOBAL_ALIGNMENT_DEFINES_SVH
`define BANDED_LINEAR_GAP_GLOBAL_ALIGNMENT_DEFINES_SVH

// property that must hold at every edge outside reset
`define BLGA_ASSERT_HOLDS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// implication checked at every edge outside reset
`define BLGA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/blga_pkg.sv -----
// ----------------------------------------------------------------------------
// blga_pkg
// Types and constants of the banded linear-gap global alignment block.
// ----------------------------------------------------------------------------
package blga_pkg;

    localparam int MAX_QUERY_LEN  = 256;
    localparam int MAX_TARGET_LEN = 256;
    localparam int SCORE_BITS     = 24;
    localparam int TB_COLS        = MAX_TARGET_LEN + 1;
    localparam int PATH_MAX_OPS   = MAX_QUERY_LEN + MAX_TARGET_LEN;

    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic signed [7:0]            t_weight;

    localparam t_score SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam t_score SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    // input opcodes
    localparam logic [1:0] OPC_LOAD_Q = 2'd0;
    localparam logic [1:0] OPC_LOAD_T = 2'd1;
    localparam logic [1:0] OPC_ALIGN  = 2'd2;
    localparam logic [1:0] OPC_READ   = 2'd3;

    // path ops
    localparam logic [1:0] PATH_M = 2'd0;
    localparam logic [1:0] PATH_D = 2'd1;
    localparam logic [1:0] PATH_I = 2'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_MATCH    = 8'd0;
    localparam logic [7:0] CFG_MISMATCH = 8'd1;
    localparam logic [7:0] CFG_GAP      = 8'd2;
    localparam logic [7:0] CFG_END_GAP  = 8'd3;
    localparam logic [7:0] CFG_RADIUS   = 8'd4;

    // operands and result of the shared score unit
    typedef struct packed {
        t_score  a;
        t_weight b;
        t_score  cmp;
    } t_alu_req;

    typedef struct packed {
        t_score sum;
        logic   gt;
    } t_alu_rsp;

endpackage

// ----- hw/rtl/banded_linear_gap_global_alignment.sv -----
// ----------------------------------------------------------------------------
// banded_linear_gap_global_alignment
// Banded Needleman-Wunsch with linear gap score, traceback and path readout.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   tuser opcode, tdata load and align fields
// m         out  o_m_tvalid / i_m_tready   tdata score, length, op; tlast last op
// cfg       in   i_cfg_valid / o_cfg_ready index, data
//
// Loads are written to the letter stores as they are accepted. A path read passes through the
// registered path memory read and the S_PATH state. An align fills row zero, then the band cells
// row by row, then walks the traceback op by op; the shared score unit does three adds per cell.
// Reset clears control and loads the configuration defaults; stores hold garbage until written.
// A finished result waits in the output register; input stalls during an align.
module banded_linear_gap_global_alignment (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,  // opcode
    input  logic [31:0] i_s_tdata,  // letter, position, query_length, target_length
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,  // final_score, path_length, path_op
    output logic        o_m_tlast,  // last_op
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT0, S_INIT, S_ROW, S_RSET, S_CR, S_CM, S_CD, S_CI,
        S_REND, S_TBR, S_TBO, S_DONE, S_PATH
    } t_state;

    t_state r_state;

    blga_pkg::t_weight r_ms, r_mm, r_gs, r_eg;
    logic [7:0]        r_radius;

    logic [8:0]  r_lq, r_lt, r_i, r_j, r_lo, r_hi, r_prev_hi, r_ti, r_tj;
    logic [9:0]  r_w, r_tn, r_pcount, r_rp;
    blga_pkg::t_score r_acc, r_col, r_diag, r_left, r_best, r_final;
    logic [1:0]  r_op;

    logic        r_ovalid, r_olast, r_plast;
    logic [39:0] r_odata;

    // memories and their registered read data
    logic [1:0]       r_qmem [0:blga_pkg::MAX_QUERY_LEN-1];
    logic [1:0]       r_tmem [0:blga_pkg::MAX_TARGET_LEN-1];
    blga_pkg::t_score r_rmem [0:blga_pkg::MAX_TARGET_LEN];
    logic [1:0]       r_tbmem [0:(blga_pkg::MAX_QUERY_LEN+1)*blga_pkg::TB_COLS-1];
    logic [1:0]       r_pmem [0:blga_pkg::PATH_MAX_OPS-1];
    logic [1:0]       r_qq, r_tq, r_tbq, r_pq;
    blga_pkg::t_score r_rowq;

    // input fields
    logic [1:0] w_letter;
    logic [7:0] w_pos;
    logic [8:0] w_qlen, w_tlen, w_lq, w_lt;
    logic       w_acc;
    assign w_letter = i_s_tdata[1:0];
    assign w_pos    = i_s_tdata[9:2];
    assign w_qlen   = i_s_tdata[18:10];
    assign w_tlen   = i_s_tdata[27:19];
    assign w_acc    = i_s_tvalid && o_s_tready;

    // length clamp into 1..max
    function automatic logic [8:0] clamp_len(input logic [8:0] v);
        logic [8:0] r;
        if (v == 9'd0) r = 9'd1;
        else if (v > 9'(blga_pkg::MAX_TARGET_LEN)) r = 9'(blga_pkg::MAX_TARGET_LEN);
        else r = v;
        return r;
    endfunction
    assign w_lq = clamp_len(w_qlen);
    assign w_lt = clamp_len(w_tlen);

    // band edges of a row
    function automatic logic [8:0] band_lo(input logic [8:0] i, input logic [9:0] w);
        logic [9:0] d;
        d = {1'b0, i} - w;
        return ({1'b0, i} > w) ? d[8:0] : 9'd1;
    endfunction
    function automatic logic [8:0] band_hi(input logic [8:0] i, input logic [9:0] w,
                                           input logic [8:0] lt);
        logic [10:0] s;
        s = {2'b0, i} + {1'b0, w};
        return (s < {2'b0, lt}) ? s[8:0] : lt;
    endfunction

    logic [8:0] w_lo, w_hi, w_hi1, w_tlo, w_thi;
    assign w_lo  = band_lo(r_i, r_w);
    assign w_hi  = band_hi(r_i, r_w, r_lt);
    assign w_hi1 = band_hi(9'd1, r_w, r_lt);
    assign w_tlo = band_lo(r_ti, r_w);
    assign w_thi = band_hi(r_ti, r_w, r_lt);

    // cell operands
    blga_pkg::t_weight w_g;
    blga_pkg::t_score  w_up;
    assign w_g  = (r_i == r_lq || r_j == r_lt) ? r_eg : r_gs;
    assign w_up = (r_j > r_prev_hi) ? blga_pkg::SCORE_MIN : r_rowq;

    // shared score unit
    blga_pkg::t_alu_req w_req;
    blga_pkg::t_alu_rsp w_rsp;
    always_comb begin
        w_req.cmp = r_best;
        case (r_state)
            S_INIT: begin
                w_req.a = r_acc;
                w_req.b = r_eg;
            end
            S_RSET: begin
                w_req.a = r_col;
                w_req.b = r_eg;
            end
            S_CM: begin
                w_req.a = r_diag;
                w_req.b = (r_qq == r_tq) ? r_ms : r_mm;
            end
            S_CI: begin
                w_req.a = w_up;
                w_req.b = w_g;
            end
            default: begin
                w_req.a = r_left;
                w_req.b = w_g;
            end
        endcase
    end

    blga_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // best and op after the query-gap step
    blga_pkg::t_score n_best;
    logic [1:0]       n_op;
    assign n_best = w_rsp.gt ? w_rsp.sum : r_best;
    assign n_op   = w_rsp.gt ? blga_pkg::PATH_I : r_op;

    // traceback op at the current cell
    logic [16:0] w_tb_waddr, w_tb_raddr;
    logic [1:0]  w_tbop;
    assign w_tb_waddr = {r_i, 8'b0} + {8'b0, r_i} + {8'b0, r_j};
    assign w_tb_raddr = {r_ti, 8'b0} + {8'b0, r_ti} + {8'b0, r_tj};
    always_comb begin
        if (r_ti == 9'd0) w_tbop = blga_pkg::PATH_D;
        else if (r_tj == 9'd0) w_tbop = blga_pkg::PATH_I;
        else if (r_tj >= w_tlo && r_tj <= w_thi && r_tbq != 2'd3) w_tbop = r_tbq;
        else w_tbop = blga_pkg::PATH_M;
    end

    // letter stores
    always_ff @(posedge i_clk) begin
        if (w_acc && i_s_tuser == blga_pkg::OPC_LOAD_Q) r_qmem[w_pos] <= w_letter;
        if (w_acc && i_s_tuser == blga_pkg::OPC_LOAD_T) r_tmem[w_pos] <= w_letter;
        r_qq <= r_qmem[8'(r_i - 9'd1)];
        r_tq <= r_tmem[8'(r_j - 9'd1)];
    end

    // score row
    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT) r_rmem[r_j] <= r_acc;
        if (r_state == S_CI) r_rmem[r_j] <= n_best;
        r_rowq <= r_rmem[(r_state == S_ROW) ? (w_lo - 9'd1) : r_j];
    end

    // traceback store
    always_ff @(posedge i_clk) begin
        if (r_state == S_CI) r_tbmem[w_tb_waddr] <= n_op;
        r_tbq <= r_tbmem[w_tb_raddr];
    end

    // path store, written backward, read from the end
    always_ff @(posedge i_clk) begin
        if (r_state == S_TBO) r_pmem[r_tn[8:0]] <= w_tbop;
        if (r_state == S_IDLE) r_pq <= r_pmem[9'(r_pcount - 10'd1 - r_rp)];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms     <= 8'sd1;
            r_mm     <= -8'sd2;
            r_gs     <= -8'sd3;
            r_eg     <= -8'sd1;
            r_radius <= 8'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                blga_pkg::CFG_MATCH:    r_ms     <= i_cfg_data;
                blga_pkg::CFG_MISMATCH: r_mm     <= i_cfg_data;
                blga_pkg::CFG_GAP:      r_gs     <= i_cfg_data;
                blga_pkg::CFG_END_GAP:  r_eg     <= i_cfg_data;
                blga_pkg::CFG_RADIUS:   r_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_out_free, w_out_load;
    assign w_out_free = !r_ovalid || i_m_tready;
    // a result enters the output register
    assign w_out_load = w_out_free && (r_state == S_DONE || r_state == S_PATH);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_rp     <= 10'd0;
            r_pcount <= 10'd0;
        end else begin
            if (w_out_load) r_ovalid <= 1'b1;
            else if (r_ovalid && i_m_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_s_tuser)
                            blga_pkg::OPC_ALIGN: begin
                                r_lq    <= w_lq;
                                r_lt    <= w_lt;
                                r_state <= S_INIT0;
                            end
                            blga_pkg::OPC_READ: begin
                                if (r_rp < r_pcount) begin
                                    r_plast <= (r_rp + 10'd1 == r_pcount);
                                    r_rp    <= r_rp + 10'd1;
                                    r_state <= S_PATH;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT0: begin
                    r_w     <= ((r_lq > r_lt) ? {1'b0, r_lq - r_lt} : {1'b0, r_lt - r_lq})
                             + {2'b0, r_radius};
                    r_j     <= 9'd0;
                    r_acc   <= '0;
                    r_final <= '0;
                    r_state <= S_INIT;
                end
                // row zero
                S_INIT: begin
                    r_acc <= w_rsp.sum;
                    if (r_j == w_hi1) begin
                        r_i       <= 9'd1;
                        r_col     <= '0;
                        r_prev_hi <= r_lt;
                        r_state   <= S_ROW;
                    end else begin
                        r_j <= r_j + 9'd1;
                    end
                end
                S_ROW: begin
                    r_lo    <= w_lo;
                    r_hi    <= w_hi;
                    r_state <= S_RSET;
                end
                // row entry from column zero or the band edge
                S_RSET: begin
                    r_col <= w_rsp.sum;
                    if (r_lo == 9'd1) begin
                        r_diag <= r_col;
                        r_left <= w_rsp.sum;
                    end else begin
                        r_diag <= r_rowq;
                        r_left <= blga_pkg::SCORE_MIN;
                    end
                    r_j     <= r_lo;
                    r_state <= (r_lo > r_hi) ? S_REND : S_CR;
                end
                S_CR: r_state <= S_CM;
                S_CM: begin
                    r_best  <= w_rsp.sum;
                    r_op    <= blga_pkg::PATH_M;
                    r_state <= S_CD;
                end
                S_CD: begin
                    if (w_rsp.gt) begin
                        r_best <= w_rsp.sum;
                        r_op   <= blga_pkg::PATH_D;
                    end
                    r_state <= S_CI;
                end
                S_CI: begin
                    r_left  <= n_best;
                    r_diag  <= w_up;
                    r_final <= n_best;
                    if (r_j == r_hi) begin
                        r_state <= S_REND;
                    end else begin
                        r_j     <= r_j + 9'd1;
                        r_state <= S_CR;
                    end
                end
                S_REND: begin
                    r_prev_hi <= r_hi;
                    if (r_i == r_lq) begin
                        r_ti    <= r_lq;
                        r_tj    <= r_lt;
                        r_tn    <= 10'd0;
                        r_state <= S_TBR;
                    end else begin
                        r_i     <= r_i + 9'd1;
                        r_state <= S_ROW;
                    end
                end
                // traceback walk
                S_TBR: r_state <= (r_ti == 9'd0 && r_tj == 9'd0) ? S_DONE : S_TBO;
                S_TBO: begin
                    r_tn <= r_tn + 10'd1;
                    if (w_tbop != blga_pkg::PATH_D) r_ti <= r_ti - 9'd1;
                    if (w_tbop != blga_pkg::PATH_I) r_tj <= r_tj - 9'd1;
                    r_state <= S_TBR;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_odata  <= {4'd0, 2'd0, r_tn, r_final};
                        r_olast  <= 1'b0;
                        r_pcount <= r_tn;
                        r_rp     <= 10'd0;
                        r_state  <= S_IDLE;
                    end
                end
                S_PATH: begin
                    if (w_out_free) begin
                        r_odata  <= {4'd0, r_pq, 10'd0, 24'd0};
                        r_olast  <= r_plast;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tlast   = r_olast;
    assign o_cfg_ready = 1'b1;

`include "banded_linear_gap_global_alignment_defines.svh"

    `BLGA_ASSERT_HOLDS(a_rp_bound, r_rp <= r_pcount, "read pointer past path count")
    `BLGA_ASSERT_IMPL(a_cell_in_band, r_state == S_CM, r_j >= r_lo && r_j <= r_hi, "off band")
    `BLGA_ASSERT_IMPL(a_path_bound, r_state == S_TBO, r_tn < 10'(blga_pkg::PATH_MAX_OPS), "path overflow")
    `BLGA_ASSERT_IMPL(a_busy_ready, r_state != S_IDLE, !o_s_tready, "ready while busy")

endmodule

// ----- hw/rtl/blga_alu.sv -----
// ----------------------------------------------------------------------------
// blga_alu
// Shared saturating score adder with a signed compare against the best so far.
// ----------------------------------------------------------------------------
module blga_alu (
    input  blga_pkg::t_alu_req i_req,
    output blga_pkg::t_alu_rsp o_rsp
);

    logic signed [blga_pkg::SCORE_BITS:0] w_wide;
    blga_pkg::t_score                     w_sat;

    // widened add
    assign w_wide = {i_req.a[blga_pkg::SCORE_BITS-1], i_req.a}
                  + {{(blga_pkg::SCORE_BITS-7){i_req.b[7]}}, i_req.b};

    // clip to score range
    always_comb begin
        if (w_wide[blga_pkg::SCORE_BITS] != w_wide[blga_pkg::SCORE_BITS-1]) begin
            w_sat = w_wide[blga_pkg::SCORE_BITS] ? blga_pkg::SCORE_MIN : blga_pkg::SCORE_MAX;
        end else begin
            w_sat = w_wide[blga_pkg::SCORE_BITS-1:0];
        end
    end

    assign o_rsp.sum = w_sat;
    assign o_rsp.gt  = (w_sat > i_req.cmp);

endmodule
